// ===== hdl/pwts_pkg.sv =====
// Shared widths, codes and constants of the perspective world-to-screen block.
package pwts_pkg;

  localparam int CoefW    = 32;
  localparam int PosW     = 32;
  localparam int ClipW    = 64;
  localparam int AbsW     = 63;
  localparam int LowBits  = 17;
  localparam int DivSteps = 45;
  localparam int QW       = 45;
  localparam int NdcFrac  = 28;
  localparam int NdcW     = 47;
  localparam int SizeW    = 15;
  localparam int ScrW     = 32;
  localparam int IdxW     = 4;
  localparam int NumCoef  = 16;
  localparam int CfgIdxW  = 8;

  // stage counts of the three pipeline sections
  localparam int XformStages = 3;
  localparam int DivStages   = DivSteps + 2;
  localparam int MapStages   = 3;
  localparam int NumStages   = XformStages + DivStages + MapStages;

  localparam int InDataW  = 136;
  localparam int OutDataW = 64;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindPoint = 1'b1;

  localparam logic [CfgIdxW-1:0] RegWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 8'd1;

  localparam logic [SizeW-1:0] WidthReset  = 15'd1920;
  localparam logic [SizeW-1:0] HeightReset = 15'd1080;

  localparam logic signed [NdcW-1:0] NdcOne = 47'sd268435456;
  localparam logic signed [NdcW-1:0] NdcLim = 47'sd35184372088832;

  localparam logic signed [ScrW-1:0] ScrMax = 32'sh7fff_ffff;
  localparam logic signed [ScrW-1:0] ScrMin = 32'sh8000_0000;

endpackage

// ===== hdl/perspective_world_to_screen.sv =====
// Pipeline: a point item passes through the transform, divide and map sections in order.
// Throughput: one item per cycle while the output is not stalled; the 45-stage quotient pipeline sets the depth.
// Load items update the coefficient store at once and give no result.
// Each stage holds its item only while the stage after it is full and stalled.
// Reset: coefficients zero, width 1920, height 1080, all stages empty.
module perspective_world_to_screen (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100]
  input  logic [pwts_pkg::InDataW-1:0]        s_axis_tdata,
  // kind[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // screen_x[31:0], screen_y[63:32]
  output logic [pwts_pkg::OutDataW-1:0]       m_axis_tdata,
  // visible[0]
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pwts_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pwts_pkg::SizeW-1:0]          cfg_data_i
);
  import pwts_pkg::*;

  localparam int DivBase = XformStages;
  localparam int MapBase = XformStages + DivStages;

  logic [NumStages:1]   v_q;
  logic [NumStages:1]   v_d;
  logic [NumStages+1:1] adv;
  logic                 accept, in_point, in_load;

  logic [SizeW-1:0] width_q, height_q;

  logic signed [ClipW-1:0] cx, cy, cw;
  logic                    div_vis, map_vis;
  logic signed [NdcW-1:0]  nx, ny;
  logic signed [ScrW-1:0]  sx, sy;

  assign s_axis_tready = adv[1];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_point = accept && (s_axis_tuser == KindPoint);
  assign in_load  = accept && (s_axis_tuser == KindLoad);

  // a stage takes new data when empty or when its successor moves
  always_comb begin
    adv[NumStages+1] = m_axis_tready;
    for (int k = NumStages; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    v_d[1] = adv[1] ? in_point : v_q[1];
    for (int k = 2; k <= NumStages; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegWidth)  width_q  <= cfg_data_i;
      if (cfg_index_i == RegHeight) height_q <= cfg_data_i;
    end
  end

  pwts_xform u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_load),
    .coef_index_i (s_axis_tdata[3:0]),
    .coef_value_i (s_axis_tdata[35:4]),
    .pos_x_i      (s_axis_tdata[67:36]),
    .pos_y_i      (s_axis_tdata[99:68]),
    .pos_z_i      (s_axis_tdata[131:100]),
    .en_i         (adv[XformStages:1]),
    .cx_o         (cx),
    .cy_o         (cy),
    .cw_o         (cw)
  );

  pwts_div u_div (
    .clk_i (clk_i),
    .en_i  (adv[DivBase+DivStages:DivBase+1]),
    .cx_i  (cx),
    .cy_i  (cy),
    .cw_i  (cw),
    .vis_o (div_vis),
    .nx_o  (nx),
    .ny_o  (ny)
  );

  pwts_map u_map (
    .clk_i    (clk_i),
    .en_i     (adv[MapBase+MapStages:MapBase+1]),
    .vis_i    (div_vis),
    .nx_i     (nx),
    .ny_i     (ny),
    .width_i  (width_q),
    .height_i (height_q),
    .vis_o    (map_vis),
    .sx_o     (sx),
    .sy_o     (sy)
  );

  assign m_axis_tvalid = v_q[NumStages];
  assign m_axis_tdata  = {sy, sx};
  assign m_axis_tuser  = map_vis;

`ifndef SYNTH
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("point not visible but coordinates nonzero");

  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_load |=> !v_q[1])
    else $error("load item entered the pipeline");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && !adv[1] |=> v_q[1])
    else $error("stalled first stage lost its item");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NumStages] |-> s_axis_tready)
    else $error("input stalled with output stage empty");
`endif

endmodule

// ===== hdl/pwts_xform.sv =====
// Coefficient store and matrix multiply of points into clip x, y and w.
module pwts_xform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [pwts_pkg::IdxW-1:0]           coef_index_i,
  input  logic signed [pwts_pkg::CoefW-1:0]   coef_value_i,
  input  logic signed [pwts_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [pwts_pkg::PosW-1:0]    pos_y_i,
  input  logic signed [pwts_pkg::PosW-1:0]    pos_z_i,
  input  logic [pwts_pkg::XformStages-1:0]    en_i,
  output logic signed [pwts_pkg::ClipW-1:0]   cx_o,
  output logic signed [pwts_pkg::ClipW-1:0]   cy_o,
  output logic signed [pwts_pkg::ClipW-1:0]   cw_o
);
  import pwts_pkg::*;

  logic signed [CoefW-1:0] coef_q [NumCoef];
  logic signed [ClipW-1:0] prod_q [3][3];
  logic signed [CoefW-1:0] trans_q [3];
  logic signed [ClipW-1:0] part_a_q [3];
  logic signed [ClipW-1:0] part_b_q [3];
  logic signed [ClipW-1:0] clip_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) coef_q[i] <= '0;
    end else if (load_i) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // lanes 0, 1, 2 compute matrix rows x, y, w
  for (genvar l = 0; l < 3; l++) begin : g_row
    localparam int Row = (l == 2) ? 3 : l;
    logic signed [ClipW-1:0] px, py, pz;

    assign px = pos_x_i * coef_q[Row];
    assign py = pos_y_i * coef_q[4 + Row];
    assign pz = pos_z_i * coef_q[8 + Row];

    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        prod_q[l][0] <= px;
        prod_q[l][1] <= py;
        prod_q[l][2] <= pz;
        trans_q[l]   <= coef_q[12 + Row];
      end
      if (en_i[1]) begin
        part_a_q[l] <= (prod_q[l][0] >>> 2) + (prod_q[l][1] >>> 2);
        part_b_q[l] <= (prod_q[l][2] >>> 2) + (ClipW'(trans_q[l]) <<< 14);
      end
      if (en_i[2]) begin
        clip_q[l] <= part_a_q[l] + part_b_q[l];
      end
    end
  end

  assign cx_o = clip_q[0];
  assign cy_o = clip_q[1];
  assign cw_o = clip_q[2];

endmodule

// ===== hdl/pwts_div.sv =====
// Pipelined restoring divider: clip x and y over clip w, one quotient bit per stage.
module pwts_div (
  input  logic                               clk_i,
  input  logic [pwts_pkg::DivStages-1:0]     en_i,
  input  logic signed [pwts_pkg::ClipW-1:0]  cx_i,
  input  logic signed [pwts_pkg::ClipW-1:0]  cy_i,
  input  logic signed [pwts_pkg::ClipW-1:0]  cw_i,
  output logic                               vis_o,
  output logic signed [pwts_pkg::NdcW-1:0]   nx_o,
  output logic signed [pwts_pkg::NdcW-1:0]   ny_o
);
  import pwts_pkg::*;

  logic [AbsW-1:0]    d_q   [DivSteps+1];
  logic               vis_q [DivSteps+1];
  logic [AbsW-1:0]    rem_q [DivSteps+1][2];
  logic [QW-1:0]      quo_q [DivSteps+1][2];
  logic [LowBits-1:0] low_q [DivSteps+1][2];
  logic               neg_q [DivSteps+1][2];
  logic               ovf_q [DivSteps+1][2];
  logic signed [NdcW-1:0] ndc_q [2];
  logic                   vis_out_q;

  logic              vis_in;
  logic [AbsW-1:0]   d_in;
  logic signed [ClipW-1:0] num_in [2];

  assign vis_in    = cw_i > 0;
  assign d_in      = vis_in ? cw_i[AbsW-1:0] : AbsW'(1);
  assign num_in[0] = cx_i;
  assign num_in[1] = cy_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q[0]   <= d_in;
      vis_q[0] <= vis_in;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic                   neg;
    logic signed [ClipW-1:0] mag;
    logic [AbsW-1:0]        ax;

    assign neg = num_in[a] < 0;
    assign mag = neg ? -num_in[a] : num_in[a];
    assign ax  = mag[AbsW-1:0];

    // quotient above the limit clamps, checked against the full dividend
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        neg_q[0][a] <= neg;
        ovf_q[0][a] <= {{LowBits{1'b0}}, ax} >= {d_in, {LowBits{1'b0}}};
        rem_q[0][a] <= AbsW'(ax[AbsW-1:LowBits]);
        low_q[0][a] <= ax[LowBits-1:0];
        quo_q[0][a] <= '0;
      end
    end

    for (genvar j = 0; j < DivSteps; j++) begin : g_bit
      logic [AbsW:0] t;
      logic [AbsW:0] diff;
      logic          ge;

      if (j < LowBits) begin : g_feed
        assign t = {rem_q[j][a], low_q[j][a][LowBits-1-j]};
      end else begin : g_zero
        assign t = {rem_q[j][a], 1'b0};
      end
      assign ge   = t >= {1'b0, d_q[j]};
      assign diff = t - {1'b0, d_q[j]};

      always_ff @(posedge clk_i) begin
        if (en_i[1+j]) begin
          rem_q[j+1][a] <= ge ? diff[AbsW-1:0] : t[AbsW-1:0];
          quo_q[j+1][a] <= {quo_q[j][a][QW-2:0], ge};
          low_q[j+1][a] <= low_q[j][a];
          neg_q[j+1][a] <= neg_q[j][a];
          ovf_q[j+1][a] <= ovf_q[j][a];
        end
      end
    end

    logic signed [NdcW-1:0] q_ext;
    logic signed [NdcW-1:0] ndc;

    assign q_ext = NdcW'(quo_q[DivSteps][a]);

    // negative quotient rounds toward minus infinity
    always_comb begin
      if (ovf_q[DivSteps][a]) begin
        ndc = neg_q[DivSteps][a] ? -NdcLim : NdcLim;
      end else if (neg_q[DivSteps][a]) begin
        ndc = -(q_ext + NdcW'(rem_q[DivSteps][a] != '0));
      end else begin
        ndc = q_ext;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[DivStages-1]) begin
        ndc_q[a] <= ndc;
      end
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_ctl
    always_ff @(posedge clk_i) begin
      if (en_i[1+j]) begin
        d_q[j+1]   <= d_q[j];
        vis_q[j+1] <= vis_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[DivStages-1]) begin
      vis_out_q <= vis_q[DivSteps];
    end
  end

  assign vis_o = vis_out_q;
  assign nx_o  = ndc_q[0];
  assign ny_o  = ndc_q[1];

endmodule

// ===== hdl/pwts_map.sv =====
// Viewport mapping of normalized coordinates to saturated Q16.16 pixels.
module pwts_map (
  input  logic                              clk_i,
  input  logic [pwts_pkg::MapStages-1:0]    en_i,
  input  logic                              vis_i,
  input  logic signed [pwts_pkg::NdcW-1:0]  nx_i,
  input  logic signed [pwts_pkg::NdcW-1:0]  ny_i,
  input  logic [pwts_pkg::SizeW-1:0]        width_i,
  input  logic [pwts_pkg::SizeW-1:0]        height_i,
  output logic                              vis_o,
  output logic signed [pwts_pkg::ScrW-1:0]  sx_o,
  output logic signed [pwts_pkg::ScrW-1:0]  sy_o
);
  import pwts_pkg::*;

  localparam int ProdW  = NdcW + SizeW + 1;
  localparam int ShiftN = NdcFrac + 1 - 16;

  logic                     vis_a_q, vis_b_q, vis_c_q;
  logic signed [NdcW-1:0]   off_q  [2];
  logic signed [ProdW-1:0]  prod_q [2];
  logic signed [ScrW-1:0]   scr_q  [2];
  logic [SizeW-1:0]         size   [2];

  assign size[0] = width_i;
  assign size[1] = height_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vis_a_q  <= vis_i;
      off_q[0] <= nx_i + NdcOne;
      off_q[1] <= NdcOne - ny_i;
    end
    if (en_i[1]) vis_b_q <= vis_a_q;
    if (en_i[2]) vis_c_q <= vis_b_q;
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [ProdW-1:0] sh;
    logic signed [ScrW-1:0]  sat;

    assign sh = prod_q[a] >>> ShiftN;

    always_comb begin
      if (!vis_b_q) begin
        sat = '0;
      end else if (sh > ProdW'(ScrMax)) begin
        sat = ScrMax;
      end else if (sh < ProdW'(ScrMin)) begin
        sat = ScrMin;
      end else begin
        sat = sh[ScrW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[1]) prod_q[a] <= off_q[a] * $signed({1'b0, size[a]});
      if (en_i[2]) scr_q[a]  <= sat;
    end
  end

  assign vis_o = vis_c_q;
  assign sx_o  = scr_q[0];
  assign sy_o  = scr_q[1];

endmodule
